### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RTBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rtbc check failed");

// next-cycle implication, disabled in reset
`define RTBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rtbc check failed");

`endif

### design/rtbc_pkg.sv
package rtbc_pkg;

	localparam int TAB_W           = 6;
	localparam int MAX_TAB         = 63;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 6;

	localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(8);

	localparam logic [CFG_IDX_W-1:0] REG_STOP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERT_ALL = 1'b1;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_EOS  = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		logic       op;
		logic [7:0] in_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic             start;
		logic [TAB_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic             done;
		logic [TAB_W-1:0] remainder;
	} rem_rsp_t;

	// zero reads as one, clamp to the widest supported stop
	function automatic logic [TAB_W-1:0] eff_tab(input logic [TAB_W-1:0] t);
		logic [TAB_W-1:0] r;
		r = t;
		if (r == '0) r = TAB_W'(1);
		if (r > TAB_W'(MAX_TAB)) r = TAB_W'(MAX_TAB);
		return r;
	endfunction

endpackage

### design/blank_run_to_tab_converter_top.sv
// Blank-run-to-tab converter. Accepts one byte word at a time and delivers the converted
// byte words in order, one per cycle at most, through a registered output; the input stalls
// while a word is being worked on. A plain byte goes out after the held-back spaces flushed
// ahead of it; a space arriving at the saturated column counts as a plain byte. The first
// space of a run is held back without output. A space that makes or lengthens a run of two
// or more waits on the bit-serial remainder unit for the next tab stop, then emits a tab for
// each stop the run reaches. A tab byte also flushes the held-back spaces ahead of it, the
// remainder unit moving the column on to the next stop after the tab has gone out. An
// end-of-stream word flushes any held-back spaces, at most 62, the last of them marked last.
module blank_run_to_tab_converter_top #(
	parameter int COLUMN_BITS = rtbc_pkg::COLUMN_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rtbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtbc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rtbc_pkg::in_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rtbc_pkg::out_word_t               out_word
);
	import rtbc_pkg::*;

	logic [TAB_W-1:0]       tab_q;
	logic                   all_q;
	logic                   out_valid_q;
	out_word_t              out_word_q;
	logic                   out_free;
	logic                   emit;
	out_word_t              emit_word;
	rem_req_t               rem_req;
	rem_rsp_t               rem_rsp;
	logic [COLUMN_BITS-1:0] rem_dividend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_q <= TAB_RESET;
			all_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STOP_WIDTH:  tab_q <= cfg_data[TAB_W-1:0];
				REG_CONVERT_ALL: all_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	rtbc_ctrl #(
		.COLUMN_BITS(COLUMN_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_word      (in_word),
		.in_stall     (in_stall),
		.stop_width   (eff_tab(tab_q)),
		.convert_all  (all_q),
		.out_free     (out_free),
		.emit         (emit),
		.emit_word    (emit_word),
		.rem_req      (rem_req),
		.rem_dividend (rem_dividend),
		.rem_rsp      (rem_rsp)
	);

	rtbc_rem #(
		.COLUMN_BITS(COLUMN_BITS)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (rem_req),
		.dividend (rem_dividend),
		.rsp      (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_word_q <= emit_word;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

### design/rtbc_rem.sv
module rtbc_rem #(
	parameter int COLUMN_BITS = rtbc_pkg::COLUMN_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rtbc_pkg::rem_req_t     req,
	input  logic [COLUMN_BITS-1:0] dividend,
	output rtbc_pkg::rem_rsp_t     rsp
);
	import rtbc_pkg::*;

	localparam int CNT_W = $clog2(COLUMN_BITS + 1);

	logic [COLUMN_BITS-1:0] sh_q;
	logic [TAB_W-1:0]       div_q;
	logic [TAB_W-1:0]       r_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [TAB_W:0]         trial;
	logic [TAB_W:0]         diff;
	logic                   fits;

	// restoring remainder, one dividend bit a cycle
	assign trial = {r_q, sh_q[COLUMN_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(COLUMN_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= dividend;
			div_q <= req.divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			r_q  <= fits ? diff[TAB_W-1:0] : trial[TAB_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = r_q;

endmodule

### design/rtbc_ctrl.sv
module rtbc_ctrl #(
	parameter int COLUMN_BITS = rtbc_pkg::COLUMN_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  rtbc_pkg::in_word_t           in_word,
	output logic                         in_stall,
	input  logic [rtbc_pkg::TAB_W-1:0]   stop_width,
	input  logic                         convert_all,
	input  logic                         out_free,
	output logic                         emit,
	output rtbc_pkg::out_word_t          emit_word,
	output rtbc_pkg::rem_req_t           rem_req,
	output logic [COLUMN_BITS-1:0]       rem_dividend,
	input  rtbc_pkg::rem_rsp_t           rem_rsp
);
	import rtbc_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FLUSH = 3'd1;
	localparam logic [2:0] S_BYTE  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_TABS  = 3'd4;

	localparam logic [1:0] K_EOS   = 2'd0;
	localparam logic [1:0] K_SPMAX = 2'd1;
	localparam logic [1:0] K_OTHER = 2'd2;

	localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

	logic [2:0]             state_q, state_d;
	logic [1:0]             kind_q, kind_d;
	logic [7:0]             byte_q, byte_d;
	logic [COLUMN_BITS-1:0] col_q, col_d;
	logic [COLUMN_BITS-1:0] rstart_q, rstart_d;
	logic [COLUMN_BITS-1:0] ns_q, ns_d;
	logic [TAB_W-1:0]       pend_q, pend_d;
	logic                   lead_q, lead_d;
	logic                   long_q, long_d;
	logic                   hold_q, hold_d;
	logic                   divtab_q, divtab_d;

	logic                   take_sp;
	logic [TAB_W-1:0]       pend_inc;
	logic [COLUMN_BITS-1:0] rstart_sp;
	logic                   long_sp;
	logic [COLUMN_BITS-1:0] div_base;
	logic [COLUMN_BITS:0]   ns_sum;
	logic [COLUMN_BITS-1:0] ns_calc;
	logic [COLUMN_BITS:0]   step_sum;
	logic [COLUMN_BITS-1:0] ns_step;
	logic                   tab_found;
	logic [COLUMN_BITS-1:0] run_gap;

	assign take_sp   = (in_word.op == OP_CHAR) && (in_word.in_byte == CH_SPACE)
		&& (convert_all || lead_q);
	assign pend_inc  = pend_q + TAB_W'(1);
	assign rstart_sp = (pend_q == '0 && !long_q) ? col_q : rstart_q;
	assign long_sp   = long_q || (pend_inc >= TAB_W'(2));

	assign div_base = divtab_q ? col_q : rstart_q;
	assign ns_sum   = {1'b0, div_base} + (COLUMN_BITS+1)'(stop_width)
		- (COLUMN_BITS+1)'(rem_rsp.remainder);
	assign ns_calc  = (ns_sum > {1'b0, COL_MAX}) ? COL_MAX : ns_sum[COLUMN_BITS-1:0];
	assign step_sum = {1'b0, ns_q} + (COLUMN_BITS+1)'(stop_width);
	assign ns_step  = (step_sum > {1'b0, COL_MAX}) ? COL_MAX : step_sum[COLUMN_BITS-1:0];

	assign tab_found = (rstart_q < col_q) && (ns_q <= col_q);
	assign run_gap   = col_q - rstart_q;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		byte_d   = byte_q;
		col_d    = col_q;
		rstart_d = rstart_q;
		ns_d     = ns_q;
		pend_d   = pend_q;
		lead_d   = lead_q;
		long_d   = long_q;
		hold_d   = hold_q;
		divtab_d = divtab_q;
		emit              = 1'b0;
		emit_word.out_byte = CH_SPACE;
		emit_word.last     = 1'b0;
		rem_req.start      = 1'b0;
		rem_req.divisor    = stop_width;
		rem_dividend       = col_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					byte_d = in_word.in_byte;
					if (in_word.op == OP_EOS) begin
						kind_d = K_EOS;
						if (pend_q != '0) begin
							state_d = S_FLUSH;
						end else begin
							col_d    = '0;
							rstart_d = '0;
							lead_d   = 1'b1;
							long_d   = 1'b0;
						end
					end else if (take_sp) begin
						if (col_q == COL_MAX) begin
							kind_d  = K_SPMAX;
							byte_d  = CH_SPACE;
							long_d  = 1'b0;
							state_d = (pend_q != '0) ? S_FLUSH : S_BYTE;
						end else begin
							rstart_d = rstart_sp;
							pend_d   = pend_inc;
							col_d    = col_q + COLUMN_BITS'(1);
							long_d   = long_sp;
							if (long_sp) begin
								rem_req.start = 1'b1;
								rem_dividend  = rstart_sp;
								divtab_d      = 1'b0;
								state_d       = S_DIV;
							end
						end
					end else begin
						kind_d  = K_OTHER;
						long_d  = 1'b0;
						state_d = (pend_q != '0) ? S_FLUSH : S_BYTE;
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					emit           = 1'b1;
					emit_word.last = (pend_q == TAB_W'(1)) && (kind_q == K_EOS);
					pend_d         = pend_q - TAB_W'(1);
					if (pend_q == TAB_W'(1)) begin
						if (kind_q == K_EOS) begin
							col_d    = '0;
							rstart_d = '0;
							lead_d   = 1'b1;
							long_d   = 1'b0;
							state_d  = S_IDLE;
						end else begin
							state_d = S_BYTE;
						end
					end
				end
			end
			S_BYTE: begin
				if (out_free) begin
					emit               = 1'b1;
					emit_word.out_byte = byte_q;
					emit_word.last     = 1'b1;
					state_d            = S_IDLE;
					if (kind_q == K_OTHER) begin
						unique case (byte_q)
							CH_NL: begin
								col_d  = '0;
								lead_d = 1'b1;
							end
							CH_TAB: begin
								rem_req.start = 1'b1;
								rem_dividend  = col_q;
								divtab_d      = 1'b1;
								state_d       = S_DIV;
							end
							CH_BS: begin
								if (col_q != '0) col_d = col_q - COLUMN_BITS'(1);
							end
							CH_CR: begin
								col_d = '0;
							end
							default: begin
								if (col_q != COL_MAX) col_d = col_q + COLUMN_BITS'(1);
								if (byte_q != CH_SPACE) lead_d = 1'b0;
							end
						endcase
					end
				end
			end
			S_DIV: begin
				if (rem_rsp.done) begin
					if (divtab_q) begin
						col_d   = ns_calc;
						state_d = S_IDLE;
					end else begin
						ns_d    = ns_calc;
						state_d = S_TABS;
					end
				end
			end
			S_TABS: begin
				// a found tab is held back until the search for the one after it decides its last flag
				if (!hold_q || out_free) begin
					if (hold_q) begin
						emit               = 1'b1;
						emit_word.out_byte = CH_TAB;
						emit_word.last     = !tab_found;
					end
					if (tab_found) begin
						hold_d   = 1'b1;
						rstart_d = ns_q;
						ns_d     = ns_step;
					end else begin
						hold_d  = 1'b0;
						pend_d  = run_gap[TAB_W-1:0];
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			kind_q   <= K_EOS;
			col_q    <= '0;
			rstart_q <= '0;
			pend_q   <= '0;
			lead_q   <= 1'b1;
			long_q   <= 1'b0;
			hold_q   <= 1'b0;
			divtab_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			kind_q   <= kind_d;
			col_q    <= col_d;
			rstart_q <= rstart_d;
			pend_q   <= pend_d;
			lead_q   <= lead_d;
			long_q   <= long_d;
			hold_q   <= hold_d;
			divtab_q <= divtab_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		ns_q   <= ns_d;
	end

endmodule

### design/rtbc_checker.sv
`include "assert_macros.svh"

module rtbc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input rtbc_pkg::in_word_t  in_word,
	input logic                out_valid,
	input logic                out_stall,
	input rtbc_pkg::out_word_t out_word
);
	import rtbc_pkg::*;

	// stalled output word holds
	`RTBC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word))

	// a passed non-space byte always yields output, so the block goes busy
	`RTBC_ASSERT_NEXT(a_byte_busy, clk, arst_n, in_valid && !in_stall && in_word.op == OP_CHAR && in_word.in_byte != CH_SPACE, in_stall)

	// once ready again only a closing word may still wait
	`RTBC_ASSERT_IMPL(a_idle_last, clk, arst_n, out_valid && !in_stall, out_word.last)

	// words before the last are held-back spaces or tabs
	`RTBC_ASSERT_IMPL(a_mid_blank, clk, arst_n, out_valid && !out_word.last, out_word.out_byte == CH_SPACE || out_word.out_byte == CH_TAB)

endmodule

bind blank_run_to_tab_converter_top rtbc_checker u_rtbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
